/* src/aabb_pcr_pkg.sv */
// Shared types, widths and helper functions for the AABB pair collision resolver.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package aabb_pcr_pkg;

	// Fixed-point format of the coordinate fields
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;

	// Size fields are one bit narrower (non-negative)
	localparam int SIZE_BITS = COORD_BITS - 1;

	// Gap register: 16-bit fraction, scaled to FRAC_BITS
	localparam int CFG_BITS      = 16;
	localparam logic [CFG_BITS-1:0] TOP_GAP_RESET = 16'd32768;
	localparam int GAP_SHL       = (FRAC_BITS >= CFG_BITS) ? (FRAC_BITS - CFG_BITS) : 0;
	localparam int GAP_SHR       = (FRAC_BITS < CFG_BITS) ? (CFG_BITS - FRAC_BITS) : 0;
	localparam int GAP_BITS      = CFG_BITS + GAP_SHL;

	// Internal widths: box edge, overlap, half overlap, resolved position
	localparam int EDGE_W = COORD_BITS + 1;
	localparam int OVL_W  = COORD_BITS + 2;
	localparam int HALF_W = OVL_W - 1;
	localparam int WIDE_W = ((COORD_BITS + 4) > (GAP_BITS + 2)) ? (COORD_BITS + 4)
		: (GAP_BITS + 2);

	// Input beat
	typedef struct packed {
		logic                          second_of_pair;
		logic signed [COORD_BITS-1:0]  box_left;
		logic signed [COORD_BITS-1:0]  box_top;
		logic        [SIZE_BITS-1:0]   box_width;
		logic        [SIZE_BITS-1:0]   box_height;
		logic signed [COORD_BITS-1:0]  pos_x;
		logic signed [COORD_BITS-1:0]  pos_y;
		logic signed [COORD_BITS-1:0]  vel_x;
		logic signed [COORD_BITS-1:0]  vel_y;
		logic                          is_static;
	} pcr_in_t;

	// Result beat
	typedef struct packed {
		logic                          which_actor;
		logic signed [COORD_BITS-1:0]  new_pos_x;
		logic signed [COORD_BITS-1:0]  new_pos_y;
		logic signed [COORD_BITS-1:0]  new_vel_x;
		logic signed [COORD_BITS-1:0]  new_vel_y;
		logic                          grounded;
	} pcr_out_t;

	// One actor: box (left, top, width, height), position, velocity, static flag
	typedef struct packed {
		logic [COORD_BITS-1:0] l;
		logic [COORD_BITS-1:0] t;
		logic [SIZE_BITS-1:0]  w;
		logic [SIZE_BITS-1:0]  h;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [COORD_BITS-1:0] vx;
		logic [COORD_BITS-1:0] vy;
		logic                  st;
	} pcr_actor_t;

	// Held first actor plus incoming second actor
	typedef struct packed {
		pcr_actor_t a;
		pcr_actor_t b;
	} pcr_pair_t;

	// Overlap stage result handed to the resolver
	typedef struct packed {
		pcr_actor_t        a;
		pcr_actor_t        b;
		logic              horiz;     // x overlap strictly smaller
		logic              a_left;    // a.px < b.px
		logic              a_upper;   // a.py < b.py
		logic [HALF_W-1:0] hw;
		logic [HALF_W-1:0] hh;
	} pcr_ovl_t;

	// Sign-extend a coordinate to the position width
	function automatic logic [WIDE_W-1:0] wide_coord(input logic [COORD_BITS-1:0] v);
		return {{(WIDE_W-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

	// Sign-extend a half overlap to the position width
	function automatic logic [WIDE_W-1:0] wide_half(input logic [HALF_W-1:0] v);
		return {{(WIDE_W-HALF_W){v[HALF_W-1]}}, v};
	endfunction

	// Gap register scaled to FRAC_BITS, zero-extended to the position width
	function automatic logic [WIDE_W-1:0] wide_gap(input logic [CFG_BITS-1:0] g);
		logic [GAP_BITS-1:0] s;
		s = {g, {GAP_SHL{1'b0}}} >> GAP_SHR;
		return {{(WIDE_W-GAP_BITS){1'b0}}, s};
	endfunction

	// Clamp a wide position to the signed coordinate range
	function automatic logic [COORD_BITS-1:0] sat_coord(input logic [WIDE_W-1:0] v);
		logic [COORD_BITS-1:0] r;
		if (v[WIDE_W-1:COORD_BITS-1] == {(WIDE_W-COORD_BITS+1){v[WIDE_W-1]}}) begin
			r = v[COORD_BITS-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/aabb_pcr_overlap.sv */
// Overlap stage: box edges, x/y overlaps, axis choice and half overlaps, registered.
// Depends on aabb_pcr_pkg.
`default_nettype none

module aabb_pcr_overlap (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire aabb_pcr_pkg::pcr_pair_t pair_s1,
	output aabb_pcr_pkg::pcr_ovl_t      ovl_s2
);
	import aabb_pcr_pkg::*;

	logic signed [EDGE_W-1:0]    ra, rb, ba, bb, min_r, min_b;
	logic signed [COORD_BITS-1:0] max_l, max_t;
	logic signed [OVL_W-1:0]     ow, oh;
	pcr_ovl_t                    ovl;

	// Right/bottom edges, then overlap = min far edge - max near edge
	always_comb begin
		ra = {pair_s1.a.l[COORD_BITS-1], pair_s1.a.l} + {2'b00, pair_s1.a.w};
		rb = {pair_s1.b.l[COORD_BITS-1], pair_s1.b.l} + {2'b00, pair_s1.b.w};
		ba = {pair_s1.a.t[COORD_BITS-1], pair_s1.a.t} + {2'b00, pair_s1.a.h};
		bb = {pair_s1.b.t[COORD_BITS-1], pair_s1.b.t} + {2'b00, pair_s1.b.h};
		min_r = (ra < rb) ? ra : rb;
		min_b = (ba < bb) ? ba : bb;
		max_l = ($signed(pair_s1.a.l) > $signed(pair_s1.b.l)) ? pair_s1.a.l : pair_s1.b.l;
		max_t = ($signed(pair_s1.a.t) > $signed(pair_s1.b.t)) ? pair_s1.a.t : pair_s1.b.t;
		ow = {min_r[EDGE_W-1], min_r} - {{2{max_l[COORD_BITS-1]}}, max_l};
		oh = {min_b[EDGE_W-1], min_b} - {{2{max_t[COORD_BITS-1]}}, max_t};
	end

	// Axis choice, position order, floor halves
	always_comb begin
		ovl.a       = pair_s1.a;
		ovl.b       = pair_s1.b;
		ovl.horiz   = (ow < oh);
		ovl.a_left  = ($signed(pair_s1.a.px) < $signed(pair_s1.b.px));
		ovl.a_upper = ($signed(pair_s1.a.py) < $signed(pair_s1.b.py));
		ovl.hw      = ow[OVL_W-1:1];
		ovl.hh      = oh[OVL_W-1:1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovl_s2 <= ovl;
		end
	end

endmodule

`default_nettype wire

/* src/aabb_pcr_resolve.sv */
// Resolver: applies the push, velocity clamp, top gap and grounded flag to both actors.
// Purely combinational; depends on aabb_pcr_pkg.
`default_nettype none

module aabb_pcr_resolve (
	input  wire aabb_pcr_pkg::pcr_ovl_t      ovl,
	input  wire logic [aabb_pcr_pkg::CFG_BITS-1:0] top_gap,
	output aabb_pcr_pkg::pcr_out_t           res0,
	output aabb_pcr_pkg::pcr_out_t           res1
);
	import aabb_pcr_pkg::*;

	logic [WIDE_W-1:0]     apx, apy, bpx, bpy, hw, hh, gap;
	logic [COORD_BITS-1:0] avx, avy, bvx, bvy;
	logic                  ga, gb;

	function automatic logic pos_nz(input logic [COORD_BITS-1:0] v);
		return !v[COORD_BITS-1] && (v != '0);
	endfunction

	always_comb begin
		hw  = wide_half(ovl.hw);
		hh  = wide_half(ovl.hh);
		gap = wide_gap(top_gap);
		apx = wide_coord(ovl.a.px);
		apy = wide_coord(ovl.a.py);
		bpx = wide_coord(ovl.b.px);
		bpy = wide_coord(ovl.b.py);
		avx = ovl.a.vx;
		avy = ovl.a.vy;
		bvx = ovl.b.vx;
		bvy = ovl.b.vy;
		ga  = 1'b0;
		gb  = 1'b0;
		if (ovl.horiz) begin
			// Horizontal push
			if (ovl.a_left) begin
				if (!ovl.a.st) begin
					apx = apx - hw;
					if (pos_nz(avx)) avx = '0;
				end
				if (!ovl.b.st) begin
					bpx = bpx + hw;
					if (bvx[COORD_BITS-1]) bvx = '0;
				end
			end else begin
				if (!ovl.a.st) begin
					apx = apx + hw;
					if (avx[COORD_BITS-1]) avx = '0;
				end
				if (!ovl.b.st) begin
					bpx = bpx - hw;
					if (pos_nz(bvx)) bvx = '0;
				end
			end
		end else begin
			// Vertical push; upper actor gets the gap and lands
			if (ovl.a_upper) begin
				if (!ovl.a.st) begin
					apy = apy - hh - gap;
					ga  = 1'b1;
					if (pos_nz(avy)) avy = '0;
				end
				if (!ovl.b.st) begin
					bpy = bpy + hh;
					if (bvy[COORD_BITS-1]) bvy = '0;
				end
			end else begin
				if (!ovl.a.st) begin
					apy = apy + hh;
					if (avy[COORD_BITS-1]) avy = '0;
				end
				if (!ovl.b.st) begin
					bpy = bpy - hh - gap;
					gb  = 1'b1;
					if (pos_nz(bvy)) bvy = '0;
				end
			end
		end
	end

	// Saturate and pack both result beats
	always_comb begin
		res0.which_actor = 1'b0;
		res0.new_pos_x   = sat_coord(apx);
		res0.new_pos_y   = sat_coord(apy);
		res0.new_vel_x   = avx;
		res0.new_vel_y   = avy;
		res0.grounded    = ga;
		res1.which_actor = 1'b1;
		res1.new_pos_x   = sat_coord(bpx);
		res1.new_pos_y   = sat_coord(bpy);
		res1.new_vel_x   = bvx;
		res1.new_vel_y   = bvy;
		res1.grounded    = gb;
	end

endmodule

`default_nettype wire

/* src/aabb_pcr_outq.sv */
// Result register: holds both results of a pair and sends them as two beats.
// Depends on aabb_pcr_pkg.
`default_nettype none

module aabb_pcr_outq (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire aabb_pcr_pkg::pcr_out_t res0,
	input  wire aabb_pcr_pkg::pcr_out_t res1,
	output logic                        free,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output aabb_pcr_pkg::pcr_out_t      out_item
);
	import aabb_pcr_pkg::*;

	logic     valid_q, idx_q;
	pcr_out_t r0_q, r1_q;

	// Free when empty or when the second beat leaves now
	assign free      = !valid_q || (out_ready && idx_q);
	assign out_valid = valid_q;
	assign out_item  = idx_q ? r1_q : r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (valid_q && out_ready) begin
			valid_q <= !idx_q;
			idx_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= res0;
			r1_q <= res1;
		end
	end

endmodule

`default_nettype wire

/* src/aabb_pair_collision_resolve.sv */
// AABB pair collision resolver, top level; depends on aabb_pcr_pkg and the stage modules.
// Path: a second actor's beat passes input, overlap and result registers; its two result
// beats then leave, the first actor's beat first. Throughput: one input beat per cycle
// while in_ready is high; each second actor yields two output beats, one per cycle while
// out_ready is high, so the result register's two-beat drain sets the rate of pairs.
// Reset clears the held actor to zero, empties the pipeline and sets top_gap to 0.5.
`default_nettype none

module aabb_pair_collision_resolve (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire aabb_pcr_pkg::pcr_in_t               in_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output aabb_pcr_pkg::pcr_out_t                   out_item,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aabb_pcr_pkg::CFG_BITS-1:0]   cfg_data
);
	import aabb_pcr_pkg::*;

	logic                gap_wr;
	logic [CFG_BITS-1:0] top_gap_q;
	pcr_actor_t          held_q, in_actor;
	pcr_pair_t           pair_s1;
	logic                valid_s1, valid_s2;
	logic                in_acc, adv_s2, load_out, out_free;
	pcr_ovl_t            ovl_s2;
	pcr_out_t            res0, res1;

	// Config register, always writable
	assign cfg_ready = 1'b1;
	assign gap_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_gap_q <= TOP_GAP_RESET;
		end else if (gap_wr) begin
			top_gap_q <= cfg_data;
		end
	end

	// Pipeline flow control
	assign load_out = valid_s2 && out_free;
	assign adv_s2   = valid_s1 && (!valid_s2 || load_out);
	assign in_ready = !valid_s1 || adv_s2;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		in_actor.l  = in_item.box_left;
		in_actor.t  = in_item.box_top;
		in_actor.w  = in_item.box_width;
		in_actor.h  = in_item.box_height;
		in_actor.px = in_item.pos_x;
		in_actor.py = in_item.pos_y;
		in_actor.vx = in_item.vel_x;
		in_actor.vy = in_item.vel_y;
		in_actor.st = in_item.is_static;
	end

	// Held first actor, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_acc && !in_item.second_of_pair) begin
			held_q <= in_actor;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc && in_item.second_of_pair) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (load_out) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register: pair snapshot
	always_ff @(posedge clk) begin
		if (in_acc && in_item.second_of_pair) begin
			pair_s1.a <= held_q;
			pair_s1.b <= in_actor;
		end
	end

	aabb_pcr_overlap u_overlap (
		.clk     (clk),
		.en      (adv_s2),
		.pair_s1 (pair_s1),
		.ovl_s2  (ovl_s2)
	);

	aabb_pcr_resolve u_resolve (
		.ovl     (ovl_s2),
		.top_gap (top_gap_q),
		.res0    (res0),
		.res1    (res1)
	);

	aabb_pcr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_out),
		.res0      (res0),
		.res1      (res1),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// First actor's beat is always followed by the second actor's
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_item.which_actor)
		|=> (out_valid && out_item.which_actor))
		else $error("second result beat missing after first");

	// At most one actor of a pair lands on top
	a_one_grounded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(res0.grounded && res1.grounded))
		else $error("both actors grounded");

	// A stalled result register never takes a new pair
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !load_out)
		else $error("result register overwritten while stalled");

	// Pipeline stage 2 is not lost under stall
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !load_out) |=> valid_s2)
		else $error("overlap stage dropped");

endmodule

`default_nettype wire

/* bench/aabb_pcr_checker.sv */
// Checker for the AABB pair collision resolver: watches the input, result and gap channels,
// resolves each pair in its own model and compares every result beat field by field.
// Depends on aabb_pcr_pkg for the beat types, widths and gap scaling constants.

module aabb_pcr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  aabb_pcr_pkg::pcr_in_t             in_item,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  aabb_pcr_pkg::pcr_out_t            out_item,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [aabb_pcr_pkg::CFG_BITS-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pcr_pkg::*;

	pcr_in_t             held_actor;
	logic [CFG_BITS-1:0] gap_reg;
	pcr_out_t            resolved_q[$];
	pcr_out_t            want, res_first, res_second;
	int                  errs = 0;

	assign fail_count = errs;

	// One line per mismatch
	task automatic report_mismatch(input string what, input logic [COORD_BITS-1:0] got,
		input logic [COORD_BITS-1:0] exp_val);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, exp_val, $realtime);
		errs++;
	endtask

	// Clamp a wide position to the signed coordinate range
	function automatic longint clamp_coord(input longint v);
		longint hi, lo;
		hi = (longint'(1) << (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// Resolve held actor a against incoming actor b along the axis of smaller overlap
	function automatic void resolve_pair(input pcr_in_t a, input pcr_in_t b,
		input logic [CFG_BITS-1:0] g, output pcr_out_t ra, output pcr_out_t rb);
		longint a_l, a_t, a_w, a_h, a_px, a_py, a_vx, a_vy;
		longint b_l, b_t, b_w, b_h, b_px, b_py, b_vx, b_vy;
		longint right_a, right_b, bot_a, bot_b, ow, oh, hw, hh, gp;
		logic   ga, gb;
		a_l = longint'(a.box_left);   a_t = longint'(a.box_top);
		a_w = longint'(a.box_width);  a_h = longint'(a.box_height);
		a_px = longint'(a.pos_x);     a_py = longint'(a.pos_y);
		a_vx = longint'(a.vel_x);     a_vy = longint'(a.vel_y);
		b_l = longint'(b.box_left);   b_t = longint'(b.box_top);
		b_w = longint'(b.box_width);  b_h = longint'(b.box_height);
		b_px = longint'(b.pos_x);     b_py = longint'(b.pos_y);
		b_vx = longint'(b.vel_x);     b_vy = longint'(b.vel_y);
		ga = 1'b0;
		gb = 1'b0;

		// exact overlaps; arithmetic shift floors the half
		right_a = a_l + a_w;
		right_b = b_l + b_w;
		bot_a = a_t + a_h;
		bot_b = b_t + b_h;
		ow = ((right_a < right_b) ? right_a : right_b) - ((a_l > b_l) ? a_l : b_l);
		oh = ((bot_a < bot_b) ? bot_a : bot_b) - ((a_t > b_t) ? a_t : b_t);
		hw = ow >>> 1;
		hh = oh >>> 1;
		gp = (longint'(g) << GAP_SHL) >>> GAP_SHR;

		if (ow < oh) begin
			// horizontal push; equal x puts the first actor on the right
			if (a_px < b_px) begin
				if (!a.is_static) begin
					a_px = a_px - hw;
					if (a_vx > 0) a_vx = 0;
				end
				if (!b.is_static) begin
					b_px = b_px + hw;
					if (b_vx < 0) b_vx = 0;
				end
			end else begin
				if (!a.is_static) begin
					a_px = a_px + hw;
					if (a_vx < 0) a_vx = 0;
				end
				if (!b.is_static) begin
					b_px = b_px - hw;
					if (b_vx > 0) b_vx = 0;
				end
			end
		end else begin
			// vertical push (ties included); upper actor gets the gap and lands
			if (a_py < b_py) begin
				if (!a.is_static) begin
					a_py = a_py - hh - gp;
					ga = 1'b1;
					if (a_vy > 0) a_vy = 0;
				end
				if (!b.is_static) begin
					b_py = b_py + hh;
					if (b_vy < 0) b_vy = 0;
				end
			end else begin
				if (!a.is_static) begin
					a_py = a_py + hh;
					if (a_vy < 0) a_vy = 0;
				end
				if (!b.is_static) begin
					b_py = b_py - hh - gp;
					gb = 1'b1;
					if (b_vy > 0) b_vy = 0;
				end
			end
		end

		ra.which_actor = 1'b0;
		ra.new_pos_x   = COORD_BITS'(clamp_coord(a_px));
		ra.new_pos_y   = COORD_BITS'(clamp_coord(a_py));
		ra.new_vel_x   = COORD_BITS'(a_vx);
		ra.new_vel_y   = COORD_BITS'(a_vy);
		ra.grounded    = ga;
		rb.which_actor = 1'b1;
		rb.new_pos_x   = COORD_BITS'(clamp_coord(b_px));
		rb.new_pos_y   = COORD_BITS'(clamp_coord(b_py));
		rb.new_vel_x   = COORD_BITS'(b_vx);
		rb.new_vel_y   = COORD_BITS'(b_vy);
		rb.grounded    = gb;
	endfunction

	// Result beats are checked before new predictions are queued at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_actor = '0;
			gap_reg = TOP_GAP_RESET;
			resolved_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (resolved_q.size() == 0) begin
					report_mismatch("result beat with nothing expected",
						COORD_BITS'(out_item.which_actor), '0);
				end else begin
					want = resolved_q.pop_front();
					if (out_item.which_actor !== want.which_actor)
						report_mismatch("which_actor", COORD_BITS'(out_item.which_actor),
							COORD_BITS'(want.which_actor));
					if (out_item.new_pos_x !== want.new_pos_x)
						report_mismatch("new_pos_x", out_item.new_pos_x, want.new_pos_x);
					if (out_item.new_pos_y !== want.new_pos_y)
						report_mismatch("new_pos_y", out_item.new_pos_y, want.new_pos_y);
					if (out_item.new_vel_x !== want.new_vel_x)
						report_mismatch("new_vel_x", out_item.new_vel_x, want.new_vel_x);
					if (out_item.new_vel_y !== want.new_vel_y)
						report_mismatch("new_vel_y", out_item.new_vel_y, want.new_vel_y);
					if (out_item.grounded !== want.grounded)
						report_mismatch("grounded", COORD_BITS'(out_item.grounded),
							COORD_BITS'(want.grounded));
				end
			end
			if (cfg_valid && cfg_ready) begin
				gap_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (!in_item.second_of_pair) begin
					held_actor = in_item;
				end else begin
					resolve_pair(held_actor, in_item, gap_reg, res_first, res_second);
					resolved_q = {resolved_q, res_first, res_second};
				end
			end
			pending <= resolved_q.size();
		end
	end

endmodule

/* bench/tb_aabb_pair_collision_resolve.sv */
// Testbench top for the AABB pair collision resolver: directed pairs, then random pairs
// under several gap settings and stall mixes, with a checker alongside the block.
// Depends on aabb_pcr_pkg, aabb_pair_collision_resolve and aabb_pcr_checker.

module tb_aabb_pair_collision_resolve;
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pcr_pkg::*;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 12;
	localparam int PHASE_ITEMS     = 216;
	localparam logic [31:0] ONE    = 32'h0001_0000;
	localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [SIZE_BITS-1:0]  S_MAX = {SIZE_BITS{1'b1}};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	pcr_in_t             in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	pcr_out_t            out_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = '0;
	int                  fail_count;
	int                  pending;

	int   in_idle_pct = 0;
	int   out_idle_pct = 0;
	logic hold_off = 1'b0;
	logic pressure_go = 1'b0;
	int   n_items = 0;
	int   n_results = 0;
	int   n_gap_writes = 0;
	int   quiet_cycles = 0;

	aabb_pair_collision_resolve uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	aabb_pcr_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off while pressure is applied
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(0, 99) >= out_idle_pct);
	end

	// Long output hold-off so the pipeline fills and back-pressures the input
	initial begin
		wait (pressure_go);
		repeat (20) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog on cycles with no beat on any channel; also counts result beats
	always @(posedge clk) begin
		if (out_valid && out_ready) n_results <= n_results + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic pcr_in_t make_actor(input int second, input logic [31:0] l,
		input logic [31:0] t, input logic [31:0] w, input logic [31:0] h,
		input logic [31:0] px, input logic [31:0] py, input logic [31:0] vx,
		input logic [31:0] vy, input int st);
		pcr_in_t it;
		it.second_of_pair = (second != 0);
		it.box_left = l;
		it.box_top = t;
		it.box_width = w[SIZE_BITS-1:0];
		it.box_height = h[SIZE_BITS-1:0];
		it.pos_x = px;
		it.pos_y = py;
		it.vel_x = vx;
		it.vel_y = vy;
		it.is_static = (st != 0);
		return it;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_size();
		case ($urandom_range(0, 19))
			0: return S_MAX;
			1: return '0;
			2: return SIZE_BITS'($urandom);
			default: return SIZE_BITS'($urandom_range(0, 'h80000));
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_vel();
		if ($urandom_range(0, 3) == 0) return pick_coord();
		return $urandom_range(0, 'h40000) - 'h20000;
	endfunction

	// Actor near a base corner (realistic overlaps) or with fully random fields
	function automatic pcr_in_t gen_actor(input logic second, input logic near,
		input logic [31:0] bx, input logic [31:0] by);
		pcr_in_t it;
		it.second_of_pair = second;
		if (near) begin
			it.box_left = bx + $urandom_range(0, 'h60000);
			it.box_top = by + $urandom_range(0, 'h60000);
			it.box_width = ($urandom_range(0, 19) == 0) ? pick_size()
				: SIZE_BITS'($urandom_range(0, 'h60000));
			it.box_height = ($urandom_range(0, 19) == 0) ? pick_size()
				: SIZE_BITS'($urandom_range(0, 'h60000));
			it.pos_x = ($urandom_range(0, 19) == 0) ? pick_coord()
				: it.box_left + $urandom_range(0, 'h20000);
			it.pos_y = ($urandom_range(0, 19) == 0) ? pick_coord()
				: it.box_top + $urandom_range(0, 'h20000);
			it.vel_x = pick_vel();
			it.vel_y = pick_vel();
			it.is_static = ($urandom_range(0, 6) == 0);
		end else begin
			it.box_left = pick_coord();
			it.box_top = pick_coord();
			it.box_width = pick_size();
			it.box_height = pick_size();
			it.pos_x = pick_coord();
			it.pos_y = pick_coord();
			it.vel_x = pick_coord();
			it.vel_y = pick_coord();
			it.is_static = 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	// Offer one input beat after an optional random gap, hold until accepted
	task automatic put_item(input pcr_in_t it);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		n_items++;
	endtask

	// Wait for all results, then for any first actor still in the pipeline
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_gap(input logic [CFG_BITS-1:0] g);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_gap_writes++;
	endtask

	// Mostly well-formed pairs; some noise pairs, lone second and lone first beats
	task automatic run_random_phase(input int target);
		int              start;
		int              kind;
		logic [31:0]     bx, by;
		pcr_in_t         a, b;
		start = n_items;
		while (n_items - start < target) begin
			kind = $urandom_range(0, 99);
			bx = ($urandom_range(0, 4) == 0) ? pick_coord()
				: $urandom_range(0, 'h200000) - 'h100000;
			by = ($urandom_range(0, 4) == 0) ? pick_coord()
				: $urandom_range(0, 'h200000) - 'h100000;
			if (kind < 80) begin
				a = gen_actor(1'b0, 1'b1, bx, by);
				b = gen_actor(1'b1, 1'b1, bx, by);
				// steer into the position and overlap ties now and then
				case ($urandom_range(0, 9))
					0: b.pos_x = a.pos_x;
					1: b.pos_y = a.pos_y;
					2: begin
						a.box_height = a.box_width;
						b.box_left = a.box_left;
						b.box_top = a.box_top;
						b.box_width = a.box_width;
						b.box_height = a.box_width;
					end
					default: ;
				endcase
				put_item(a);
				put_item(b);
			end else if (kind < 90) begin
				put_item(gen_actor(1'b0, 1'b0, bx, by));
				put_item(gen_actor(1'b1, 1'b0, bx, by));
			end else if (kind < 95) begin
				put_item(gen_actor(1'b1, 1'($urandom_range(0, 1)), bx, by));
			end else begin
				put_item(gen_actor(1'b0, 1'($urandom_range(0, 1)), bx, by));
			end
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] gap_plan [6];
		gap_plan[0] = '0;
		gap_plan[1] = '1;
		gap_plan[2] = CFG_BITS'($urandom);
		gap_plan[3] = 16'd1;
		gap_plan[4] = CFG_BITS'($urandom);
		gap_plan[5] = TOP_GAP_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// second actor with nothing held: resolved against the all-zero reset actor
		put_item(make_actor(1, 0, 0, 2*ONE, 2*ONE, ONE, ONE, -ONE, -ONE, 0));
		// vertical landing, first actor on top
		put_item(make_actor(0, 0, 0, 4*ONE, 4*ONE, 0, 0, ONE, 2*ONE, 0));
		put_item(make_actor(1, ONE, 3*ONE, 4*ONE, 4*ONE, ONE, 3*ONE, -ONE, -ONE, 0));
		// horizontal, first actor on the left
		put_item(make_actor(0, 0, 0, 4*ONE, 8*ONE, 0, 0, ONE, ONE, 0));
		put_item(make_actor(1, 3*ONE, 0, 4*ONE, 8*ONE, 3*ONE, 0, -ONE, ONE, 0));
		// horizontal, first actor on the right
		put_item(make_actor(0, 3*ONE, 0, 4*ONE, 8*ONE, 3*ONE, 0, -ONE, ONE, 0));
		put_item(make_actor(1, 0, 0, 4*ONE, 8*ONE, 0, 0, ONE, -ONE, 0));
		// vertical, second actor on top
		put_item(make_actor(0, 0, 3*ONE, 4*ONE, 4*ONE, 0, 3*ONE, ONE, -ONE, 0));
		put_item(make_actor(1, ONE, 0, 4*ONE, 4*ONE, ONE, 0, ONE, 2*ONE, 0));
		// equal overlaps and equal positions: vertical, first actor taken as lower
		put_item(make_actor(0, 0, 0, 4*ONE, 4*ONE, ONE, ONE, ONE, -ONE, 0));
		put_item(make_actor(1, 2*ONE, 2*ONE, 4*ONE, 4*ONE, ONE, ONE, -ONE, ONE, 0));
		// horizontal with equal x: first actor taken as the right one
		put_item(make_actor(0, 0, 0, 4*ONE, 8*ONE, 5*ONE, 0, -ONE, 0, 0));
		put_item(make_actor(1, 3*ONE, 0, 4*ONE, 8*ONE, 5*ONE, 0, ONE, 0, 0));
		// static first actor stays put
		put_item(make_actor(0, 0, 0, 4*ONE, 4*ONE, 0, 0, ONE, 2*ONE, 1));
		put_item(make_actor(1, ONE, 3*ONE, 4*ONE, 4*ONE, ONE, 3*ONE, -ONE, -ONE, 0));
		// separated boxes, odd negative overlap pulls them together
		put_item(make_actor(0, 0, 0, ONE, 8*ONE, 0, 0, -ONE, 0, 0));
		put_item(make_actor(1, 5*ONE + 1, 0, ONE, 8*ONE, 5*ONE, 0, ONE, 0, 0));
		// another second actor against the same held actor
		put_item(make_actor(1, 2*ONE, 0, ONE, 8*ONE, 2*ONE, 0, 3*ONE, 0, 1));
		// extreme corners and sizes
		put_item(make_actor(0, C_MIN, C_MIN, {1'b0, S_MAX}, {1'b0, S_MAX},
			C_MAX, C_MIN, C_MAX, C_MIN, 0));
		put_item(make_actor(1, C_MAX, C_MAX, {1'b0, S_MAX}, {1'b0, S_MAX},
			C_MIN, C_MAX, C_MIN, C_MAX, 0));
		// vertical push saturating both positions
		put_item(make_actor(0, 0, 0, 8*ONE, 2*ONE, 0, C_MIN, 0, ONE, 0));
		put_item(make_actor(1, 0, ONE, 8*ONE, 2*ONE, 0, C_MAX, 0, -ONE, 0));
		// horizontal push saturating both positions
		put_item(make_actor(0, 0, 0, 2*ONE, 8*ONE, C_MAX, 0, -ONE, 0, 0));
		put_item(make_actor(1, ONE, 0, 2*ONE, 8*ONE, C_MIN, 0, ONE, 0, 0));
		// both static: nothing moves, nobody grounded
		put_item(make_actor(0, 0, 0, 4*ONE, 4*ONE, 0, 0, ONE, ONE, 1));
		put_item(make_actor(1, ONE, 3*ONE, 4*ONE, 4*ONE, ONE, 3*ONE, -ONE, -ONE, 1));

		// random phases: two gap settings per stall mix
		for (int p = 0; p < 6; p++) begin
			write_gap(gap_plan[p]);
			case (p / 2)
				0: begin
					in_idle_pct = 11;
					out_idle_pct <= 70;
				end
				1: begin
					in_idle_pct = 70;
					out_idle_pct <= 11;
				end
				default: begin
					in_idle_pct = 0;
					out_idle_pct <= 0;
				end
			endcase
			if (p == 5) pressure_go = 1'b1;
			run_random_phase(PHASE_ITEMS);
		end
		wait_idle();

		$display("Covered %0d input beats and %0d result beats over %0d gap writes,",
			n_items, n_results, n_gap_writes);
		$display("with stall mixes 11/70, 70/11, none, and a %0d-cycle output hold-off.",
			HOLD_OFF_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
src/aabb_pcr_pkg.sv
src/aabb_pcr_overlap.sv
src/aabb_pcr_resolve.sv
src/aabb_pcr_outq.sv
src/aabb_pair_collision_resolve.sv
bench/aabb_pcr_checker.sv
bench/tb_aabb_pair_collision_resolve.sv
